FILE: hw/rtl/gtmc_pkg.sv
// shared constants and types of the growing-tree maze carver
// no dependencies; used by the interfaces, the divider and the top level
`default_nettype none

package gtmc_pkg;

	localparam int MAX_SIDE = 64;
	localparam int SIDE_W   = 6;
	localparam int CELL_W   = 2 * SIDE_W;
	localparam int CELLS    = MAX_SIDE * MAX_SIDE;
	localparam int CNT_W    = CELL_W + 1;
	localparam int DIM_W    = 7;
	localparam int WGT_W    = 7;
	localparam int RAND_W   = 15;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP   = 2'd3;

	localparam logic [1:0] DIR_NORTH = 2'd0;
	localparam logic [1:0] DIR_WEST  = 2'd1;
	localparam logic [1:0] DIR_SOUTH = 2'd2;
	localparam logic [1:0] DIR_EAST  = 2'd3;

	typedef struct packed {
		logic              start;
		logic [RAND_W-1:0] dividend;
		logic [CNT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] rem;
	} div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gtmc_if.sv
// channel interfaces: command items in, result items out, register writes
// depends on gtmc_pkg
`default_nettype none

interface gtmc_in_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 command;
	logic [gtmc_pkg::SIDE_W-1:0] cell_row;
	logic [gtmc_pkg::SIDE_W-1:0] cell_col;
	logic [gtmc_pkg::WGT_W-1:0]  cell_weight;
	logic [gtmc_pkg::RAND_W-1:0] rand_jump;
	logic [gtmc_pkg::RAND_W-1:0] rand_index;
	logic [gtmc_pkg::RAND_W-1:0] rand_dir;
	modport source (output valid, command, cell_row, cell_col, cell_weight,
		rand_jump, rand_index, rand_dir, input ready);
	modport sink (input valid, command, cell_row, cell_col, cell_weight,
		rand_jump, rand_index, rand_dir, output ready);
endinterface

interface gtmc_out_if;
	logic                        valid;
	logic                        ready;
	logic [gtmc_pkg::SIDE_W-1:0] from_row;
	logic [gtmc_pkg::SIDE_W-1:0] from_col;
	logic [1:0]                  carve_dir;
	logic                        carved;
	logic                        seed_removed;
	logic                        finished;
	logic [gtmc_pkg::CNT_W-1:0]  seeds_left;
	modport source (output valid, from_row, from_col, carve_dir, carved,
		seed_removed, finished, seeds_left, input ready);
	modport sink (input valid, from_row, from_col, carve_dir, carved,
		seed_removed, finished, seeds_left, output ready);
endinterface

interface gtmc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [gtmc_pkg::CFG_IDX_W-1:0] index;
	logic [gtmc_pkg::CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/growing_tree_maze_carver_unit.sv
// growing-tree maze carver top level: sequencer, cell stores and result register
// depends on gtmc_pkg, gtmc_if (channel interfaces) and gtmc_divider
//
// channel   role   handshake          moves
// cfg       sink   valid/ready        register index and write data
// item_in   sink   valid/ready        one command item (start, load, step)
// item_out  source valid/ready        one result item per command item
//
// sequence: load, unused code or idle step go straight to the result; start takes two
// remainders (row, column), then a sweep of all 4096 passage entries; step in newest mode
// takes up to three remainders (jump test, jump target, direction); weighted mode scans
// up to SEARCH_WINDOW seeds in span in place of the jump remainders
// reset: a sweep clears the passage store, item_in.ready stays low
// stalls: cfg is always ready; the next item is taken while a result waits,
// but it is not finished until the result register is free
`default_nettype none

module growing_tree_maze_carver_unit #(
	parameter int SEARCH_WINDOW = 100,
	parameter int TOP_WEIGHT    = 100
) (
	input  wire              clk,
	input  wire              arst_n,
	gtmc_cfg_if.sink         cfg,
	gtmc_in_if.sink          item_in,
	gtmc_out_if.source       item_out
);

	localparam int CW = gtmc_pkg::CELL_W;
	localparam int NW = gtmc_pkg::CNT_W;
	localparam int SW = gtmc_pkg::SIDE_W;
	localparam int DW = gtmc_pkg::DIM_W;
	localparam int TW = 8;

	typedef enum logic [13:0] {
		ST_CLEAR    = 14'b00000000000001,
		ST_IDLE     = 14'b00000000000010,
		ST_DIV_GO   = 14'b00000000000100,
		ST_DIV_WAIT = 14'b00000000001000,
		ST_SCAN     = 14'b00000000010000,
		ST_SEED_RD  = 14'b00000000100000,
		ST_SEED_WT  = 14'b00000001000000,
		ST_NBR      = 14'b00000010000000,
		ST_CHOOSE   = 14'b00000100000000,
		ST_REM_RD   = 14'b00001000000000,
		ST_REM_WT   = 14'b00010000000000,
		ST_CARVE1   = 14'b00100000000000,
		ST_CARVE2   = 14'b01000000000000,
		ST_DONE     = 14'b10000000000000
	} state_t;

	typedef enum logic [2:0] {
		JOB_ROW, JOB_COL, JOB_JUMP, JOB_IDX, JOB_DIR
	} job_t;

	state_t state_q;
	job_t   job_q;

	// configuration registers
	logic [DW-1:0] grid_w_q, grid_h_q;
	logic          mode_q;
	logic [7:0]    jump_q;

	// captured item
	logic [SW-1:0]               row_q, col_q;
	logic [gtmc_pkg::RAND_W-1:0] rj_q, ri_q, rd_q;

	// working registers
	logic [NW-1:0] total_q;
	logic [CW-1:0] clr_q;
	logic          start_pend_q;
	logic [SW-1:0] fr_q, fc_q;
	logic [1:0]    dir_q, sel_q;
	logic          carved_q, removed_q;
	logic [CW-1:0] idx_q, cell_q;
	logic [2:0]    nb_q;
	logic [3:0]    open_q, old_q;

	// weighted scan pipeline
	logic [NW-1:0] issue_k_q;
	logic          v_s1, v_s2;
	logic [CW-1:0] k_s1, k_s2;
	logic [TW-1:0] top_q;
	logic [CW-1:0] best_q;

	// result register
	logic          out_valid_q;
	logic [SW-1:0] o_row_q, o_col_q;
	logic [1:0]    o_dir_q;
	logic          o_carved_q, o_removed_q, o_fin_q;
	logic [NW-1:0] o_left_q;

	// stores
	logic [3:0]               pass_mem [gtmc_pkg::CELLS];
	logic [CW-1:0]            seed_mem [gtmc_pkg::CELLS];
	logic [gtmc_pkg::WGT_W-1:0] wgt_mem [gtmc_pkg::CELLS];

	logic          pass_we, seed_we, wgt_we;
	logic [CW-1:0] pass_waddr, pass_raddr, seed_waddr, seed_raddr, wgt_waddr, wgt_raddr;
	logic [3:0]    pass_wdata, pass_rdata;
	logic [CW-1:0] seed_wdata, seed_rdata;
	logic [gtmc_pkg::WGT_W-1:0] wgt_wdata, wgt_rdata;

	gtmc_pkg::div_req_t div_req;
	gtmc_pkg::div_rsp_t div_rsp;

	gtmc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	function automatic logic [DW-1:0] eff_side(input logic [DW-1:0] v);
		if (v == '0) return DW'(1);
		if (v > DW'(gtmc_pkg::MAX_SIDE)) return DW'(gtmc_pkg::MAX_SIDE);
		return v;
	endfunction

	logic [DW-1:0] eff_w, eff_h;
	logic [7:0]    eff_jump;
	assign eff_w    = eff_side(grid_w_q);
	assign eff_h    = eff_side(grid_h_q);
	assign eff_jump = (jump_q == '0) ? 8'd1 : jump_q;

	// seed cell coordinates and neighbour validity
	logic [SW-1:0] cell_r, cell_c;
	logic [3:0]    nb_ok;
	assign cell_r = cell_q[CW-1:SW];
	assign cell_c = cell_q[SW-1:0];
	assign nb_ok[gtmc_pkg::DIR_NORTH] = (cell_r != '0);
	assign nb_ok[gtmc_pkg::DIR_WEST]  = (cell_c != '0);
	assign nb_ok[gtmc_pkg::DIR_SOUTH] = ({1'b0, cell_r} + DW'(1)) < eff_h;
	assign nb_ok[gtmc_pkg::DIR_EAST]  = ({1'b0, cell_c} + DW'(1)) < eff_w;

	function automatic logic [CW-1:0] step_cell(input logic [CW-1:0] c, input logic [1:0] d);
		case (d)
			gtmc_pkg::DIR_NORTH: return c - CW'(gtmc_pkg::MAX_SIDE);
			gtmc_pkg::DIR_WEST:  return c - CW'(1);
			gtmc_pkg::DIR_SOUTH: return c + CW'(gtmc_pkg::MAX_SIDE);
			default:             return c + CW'(1);
		endcase
	endfunction

	// open neighbour count and the sel-th open direction in north, west, south, east order
	logic [2:0] open_n;
	logic [1:0] dir_pick;
	assign open_n = 3'($countones(open_q));

	always_comb begin
		logic [1:0] seen;
		seen     = '0;
		dir_pick = gtmc_pkg::DIR_NORTH;
		for (int i = 0; i < 4; i++) begin
			if (open_q[i]) begin
				if (seen == sel_q) dir_pick = 2'(i);
				seen = 2'(seen + 2'd1);
			end
		end
	end

	logic [CW-1:0] next_cell;
	assign next_cell = step_cell(cell_q, dir_q);

	// weighted window bounds
	logic [NW-1:0] win, span;
	assign win  = NW'(SEARCH_WINDOW);
	assign span = (total_q > win) ? win : total_q;

	logic [TW-1:0] w_ext;
	logic          scan_hit, scan_top, scan_end;
	assign w_ext    = TW'(wgt_rdata);
	assign scan_hit = v_s2 && (w_ext > top_q);
	assign scan_top = scan_hit && (w_ext == TW'(TOP_WEIGHT));
	assign scan_end = (issue_k_q >= total_q) && !v_s1 && !v_s2;

	logic in_fire, out_load;
	assign item_in.ready = (state_q == ST_IDLE);
	assign in_fire  = item_in.valid && item_in.ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || item_out.ready);
	assign cfg.ready = 1'b1;

	// divider operands by job
	always_comb begin
		div_req.start = (state_q == ST_DIV_GO);
		case (job_q)
			JOB_ROW: begin
				div_req.dividend = gtmc_pkg::RAND_W'(row_q);
				div_req.divisor  = NW'(eff_h);
			end
			JOB_COL: begin
				div_req.dividend = gtmc_pkg::RAND_W'(col_q);
				div_req.divisor  = NW'(eff_w);
			end
			JOB_JUMP: begin
				div_req.dividend = rj_q;
				div_req.divisor  = NW'(eff_jump);
			end
			JOB_IDX: begin
				div_req.dividend = ri_q;
				div_req.divisor  = total_q;
			end
			default: begin
				div_req.dividend = rd_q;
				div_req.divisor  = NW'(open_n);
			end
		endcase
	end

	// store port selection
	always_comb begin
		pass_we    = 1'b0;
		pass_waddr = clr_q;
		pass_wdata = '0;
		pass_raddr = step_cell(cell_q, nb_q[1:0]);
		seed_we    = 1'b0;
		seed_waddr = idx_q;
		seed_wdata = seed_rdata;
		seed_raddr = idx_q;
		wgt_we     = 1'b0;
		wgt_waddr  = {item_in.cell_row, item_in.cell_col};
		wgt_wdata  = item_in.cell_weight;
		wgt_raddr  = seed_rdata;
		unique case (state_q)
			ST_CLEAR: begin
				pass_we = 1'b1;
				if (clr_q == '1 && start_pend_q) begin
					seed_we    = 1'b1;
					seed_waddr = '0;
					seed_wdata = {fr_q, fc_q};
				end
			end
			ST_IDLE: begin
				wgt_we = in_fire && (item_in.command == gtmc_pkg::CMD_LOAD);
			end
			ST_SCAN: begin
				seed_raddr = issue_k_q[CW-1:0];
			end
			ST_NBR: begin
				if (nb_q >= 3'd4) pass_raddr = cell_q;
			end
			ST_REM_RD: begin
				seed_raddr = CW'(total_q - NW'(1));
			end
			ST_REM_WT: begin
				seed_we = 1'b1;
			end
			ST_CARVE1: begin
				pass_we    = 1'b1;
				pass_waddr = cell_q;
				pass_wdata = old_q | (4'b0001 << dir_pick);
				pass_raddr = step_cell(cell_q, dir_pick);
			end
			ST_CARVE2: begin
				pass_we    = 1'b1;
				pass_waddr = next_cell;
				pass_wdata = pass_rdata | (4'b0001 << (dir_q ^ 2'b10));
				seed_we    = (total_q < NW'(gtmc_pkg::CELLS));
				seed_waddr = total_q[CW-1:0];
				seed_wdata = next_cell;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pass_we) pass_mem[pass_waddr] <= pass_wdata;
		pass_rdata <= pass_mem[pass_raddr];
	end

	always_ff @(posedge clk) begin
		if (seed_we) seed_mem[seed_waddr] <= seed_wdata;
		seed_rdata <= seed_mem[seed_raddr];
	end

	always_ff @(posedge clk) begin
		if (wgt_we) wgt_mem[wgt_waddr] <= wgt_wdata;
		wgt_rdata <= wgt_mem[wgt_raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= DW'(64);
			grid_h_q <= DW'(64);
			mode_q   <= 1'b0;
			jump_q   <= 8'd8;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				gtmc_pkg::REG_WIDTH:  grid_w_q <= cfg.data[DW-1:0];
				gtmc_pkg::REG_HEIGHT: grid_h_q <= cfg.data[DW-1:0];
				gtmc_pkg::REG_MODE:   mode_q   <= cfg.data[0];
				gtmc_pkg::REG_JUMP:   jump_q   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			job_q        <= JOB_ROW;
			clr_q        <= '0;
			start_pend_q <= 1'b0;
			total_q      <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == '1) begin
						if (start_pend_q) begin
							total_q <= NW'(1);
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_IDLE;
						end
						start_pend_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						case (item_in.command)
							gtmc_pkg::CMD_START: begin
								job_q   <= JOB_ROW;
								state_q <= ST_DIV_GO;
							end
							gtmc_pkg::CMD_STEP: begin
								if (total_q == '0) begin
									state_q <= ST_DONE;
								end else if (mode_q) begin
									state_q <= ST_SCAN;
								end else begin
									job_q   <= JOB_JUMP;
									state_q <= ST_DIV_GO;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						case (job_q)
							JOB_ROW: begin
								job_q   <= JOB_COL;
								state_q <= ST_DIV_GO;
							end
							JOB_COL: begin
								start_pend_q <= 1'b1;
								clr_q        <= '0;
								state_q      <= ST_CLEAR;
							end
							JOB_JUMP: begin
								if (div_rsp.rem == '0) begin
									job_q   <= JOB_IDX;
									state_q <= ST_DIV_GO;
								end else begin
									state_q <= ST_SEED_RD;
								end
							end
							JOB_IDX: state_q <= ST_SEED_RD;
							default: state_q <= ST_CARVE1;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_top || scan_end) begin
						v_s1    <= 1'b0;
						v_s2    <= 1'b0;
						state_q <= ST_SEED_RD;
					end else begin
						v_s1 <= (issue_k_q < total_q);
						v_s2 <= v_s1;
					end
				end
				ST_SEED_RD: state_q <= ST_SEED_WT;
				ST_SEED_WT: state_q <= ST_NBR;
				ST_NBR: begin
					if (nb_q == 3'd5) state_q <= ST_CHOOSE;
				end
				ST_CHOOSE: begin
					if (open_q == '0) begin
						state_q <= ST_REM_RD;
					end else begin
						job_q   <= JOB_DIR;
						state_q <= ST_DIV_GO;
					end
				end
				ST_REM_RD: state_q <= ST_REM_WT;
				ST_REM_WT: begin
					total_q <= total_q - NW'(1);
					state_q <= ST_DONE;
				end
				ST_CARVE1: state_q <= ST_CARVE2;
				ST_CARVE2: begin
					if (total_q < NW'(gtmc_pkg::CELLS)) total_q <= total_q + NW'(1);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working data, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				row_q     <= item_in.cell_row;
				col_q     <= item_in.cell_col;
				rj_q      <= item_in.rand_jump;
				ri_q      <= item_in.rand_index;
				rd_q      <= item_in.rand_dir;
				fr_q      <= '0;
				fc_q      <= '0;
				dir_q     <= gtmc_pkg::DIR_NORTH;
				carved_q  <= 1'b0;
				removed_q <= 1'b0;
				// weighted scan setup
				issue_k_q <= total_q - span;
				best_q    <= CW'(total_q - NW'(1));
				top_q     <= '0;
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					case (job_q)
						JOB_ROW:  fr_q <= div_rsp.rem[SW-1:0];
						JOB_COL:  fc_q <= div_rsp.rem[SW-1:0];
						JOB_JUMP: idx_q <= CW'(total_q - NW'(1));
						JOB_IDX:  idx_q <= div_rsp.rem[CW-1:0];
						default:  sel_q <= div_rsp.rem[1:0];
					endcase
				end
			end
			ST_SCAN: begin
				if (issue_k_q < total_q) issue_k_q <= issue_k_q + NW'(1);
				k_s1 <= issue_k_q[CW-1:0];
				k_s2 <= k_s1;
				if (scan_hit) begin
					top_q  <= w_ext;
					best_q <= k_s2;
				end
				if (scan_top) idx_q <= k_s2;
				else if (scan_end) idx_q <= best_q;
			end
			ST_SEED_WT: begin
				cell_q <= seed_rdata;
				fr_q   <= seed_rdata[CW-1:SW];
				fc_q   <= seed_rdata[SW-1:0];
				nb_q   <= '0;
				open_q <= '0;
			end
			ST_NBR: begin
				nb_q <= nb_q + 3'd1;
				if (nb_q >= 3'd1 && nb_q <= 3'd4) begin
					open_q[2'(nb_q - 3'd1)] <= nb_ok[2'(nb_q - 3'd1)] && (pass_rdata == '0);
				end
				if (nb_q == 3'd5) old_q <= pass_rdata;
			end
			ST_REM_WT: removed_q <= 1'b1;
			ST_CARVE1: begin
				dir_q    <= dir_pick;
				carved_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// result register, freed as soon as the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (item_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_row_q     <= fr_q;
			o_col_q     <= fc_q;
			o_dir_q     <= dir_q;
			o_carved_q  <= carved_q;
			o_removed_q <= removed_q;
			o_fin_q     <= (total_q == '0);
			o_left_q    <= total_q;
		end
	end

	assign item_out.valid        = out_valid_q;
	assign item_out.from_row     = o_row_q;
	assign item_out.from_col     = o_col_q;
	assign item_out.carve_dir    = o_dir_q;
	assign item_out.carved       = o_carved_q;
	assign item_out.seed_removed = o_removed_q;
	assign item_out.finished     = o_fin_q;
	assign item_out.seeds_left   = o_left_q;

endmodule

`default_nettype wire

FILE: hw/rtl/gtmc_divider.sv
// iterative restoring remainder unit, one dividend bit per cycle
// depends on gtmc_pkg
`default_nettype none

module gtmc_divider (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire gtmc_pkg::div_req_t  req,
	output gtmc_pkg::div_rsp_t       rsp
);

	localparam int STEPS = gtmc_pkg::RAND_W;
	localparam int STEP_W = $clog2(STEPS + 1);

	logic [STEP_W-1:0]             cnt_q;
	logic                          done_q;
	logic [gtmc_pkg::RAND_W-1:0]   dvd_q;
	logic [gtmc_pkg::CNT_W-1:0]    dvs_q;
	logic [gtmc_pkg::CNT_W-1:0]    rem_q;
	logic [gtmc_pkg::CNT_W:0]      trial;

	// shift next dividend bit into the partial remainder
	assign trial = {rem_q, dvd_q[gtmc_pkg::RAND_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= STEP_W'(STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[gtmc_pkg::RAND_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) rem_q <= gtmc_pkg::CNT_W'(trial - {1'b0, dvs_q});
			else rem_q <= trial[gtmc_pkg::CNT_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// self-checking testbench of the growing-tree maze carver: directed and random items
// depends on gtmc_pkg, gtmc_if and the growing_tree_maze_carver_unit top level
`default_nettype none

module testbench;

	typedef struct {
		logic [1:0]                  command;
		logic [gtmc_pkg::SIDE_W-1:0] row;
		logic [gtmc_pkg::SIDE_W-1:0] col;
		logic [gtmc_pkg::WGT_W-1:0]  weight;
		logic [gtmc_pkg::RAND_W-1:0] rj;
		logic [gtmc_pkg::RAND_W-1:0] ri;
		logic [gtmc_pkg::RAND_W-1:0] rd;
	} carve_item_t;

	typedef struct {
		logic [gtmc_pkg::SIDE_W-1:0] from_row;
		logic [gtmc_pkg::SIDE_W-1:0] from_col;
		logic [1:0]                  carve_dir;
		logic                        carved;
		logic                        seed_removed;
		logic                        finished;
		logic [gtmc_pkg::CNT_W-1:0]  seeds_left;
	} carve_result_t;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int WINDOW = 100;
	localparam int HEAVIEST = 100;
	localparam int CELLS = gtmc_pkg::CELLS;
	localparam int MAX_SIDE = gtmc_pkg::MAX_SIDE;

	logic clk;
	logic arst_n;

	gtmc_cfg_if cfg_ch();
	gtmc_in_if  in_ch();
	gtmc_out_if out_ch();

	growing_tree_maze_carver_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_ch.sink),
		.item_in  (in_ch.sink),
		.item_out (out_ch.source)
	);

	// model state of the carver
	logic [3:0]                  mdl_marks[CELLS];
	logic [gtmc_pkg::CELL_W-1:0] mdl_seeds[CELLS];
	logic [gtmc_pkg::WGT_W-1:0]  mdl_weights[CELLS];
	int                          mdl_seed_cnt;
	int                          mdl_width, mdl_height, mdl_mode, mdl_jump;

	carve_item_t   pending_items[$];
	carve_result_t expected_results[$];
	int            fail_count;
	int            src_idle_pct, snk_stall_pct;

	carve_item_t   taken_item;
	carve_result_t seen_result, want_result;

	always #5 clk = ~clk;

	function automatic int eff_side(int v);
		if (v == 0) return 1;
		if (v > MAX_SIDE) return MAX_SIDE;
		return v;
	endfunction

	// next state and result of one command item
	function automatic carve_result_t carve_predict(carve_item_t it);
		carve_result_t r;
		int w, h, jf, idx, seed_at, n, k, span, top, wv, nxt, dir, fr, fc;
		int open_dirs[4];
		bit stop;
		r = '{default: '0};
		w = eff_side(mdl_width);
		h = eff_side(mdl_height);
		if (it.command == gtmc_pkg::CMD_START) begin
			for (k = 0; k < CELLS; k++) mdl_marks[k] = 4'd0;
			fr = int'(it.row) % h;
			fc = int'(it.col) % w;
			r.from_row = gtmc_pkg::SIDE_W'(fr);
			r.from_col = gtmc_pkg::SIDE_W'(fc);
			mdl_seeds[0] = gtmc_pkg::CELL_W'(fr * MAX_SIDE + fc);
			mdl_seed_cnt = 1;
		end else if (it.command == gtmc_pkg::CMD_LOAD) begin
			mdl_weights[{it.row, it.col}] = it.weight;
		end else if (it.command == gtmc_pkg::CMD_STEP && mdl_seed_cnt > 0) begin
			if (mdl_mode != 0) begin
				// heaviest of the newest window, early out at top weight
				span = mdl_seed_cnt > WINDOW ? WINDOW : mdl_seed_cnt;
				idx = mdl_seed_cnt - 1;
				top = 0;
				stop = 0;
				for (k = mdl_seed_cnt - span; k < mdl_seed_cnt && !stop; k++) begin
					wv = int'(mdl_weights[mdl_seeds[k]]);
					if (wv > top) begin
						top = wv;
						idx = k;
						if (wv == HEAVIEST) stop = 1;
					end
				end
			end else begin
				jf = mdl_jump == 0 ? 1 : mdl_jump;
				if (int'(it.rj) % jf == 0) idx = int'(it.ri) % mdl_seed_cnt;
				else idx = mdl_seed_cnt - 1;
			end
			seed_at = int'(mdl_seeds[idx]);
			fr = seed_at / MAX_SIDE;
			fc = seed_at % MAX_SIDE;
			r.from_row = gtmc_pkg::SIDE_W'(fr);
			r.from_col = gtmc_pkg::SIDE_W'(fc);
			n = 0;
			if (fr > 0 && mdl_marks[seed_at - MAX_SIDE] == 0) begin
				open_dirs[n] = gtmc_pkg::DIR_NORTH; n++;
			end
			if (fc > 0 && mdl_marks[seed_at - 1] == 0) begin
				open_dirs[n] = gtmc_pkg::DIR_WEST; n++;
			end
			if (fr + 1 < h && mdl_marks[seed_at + MAX_SIDE] == 0) begin
				open_dirs[n] = gtmc_pkg::DIR_SOUTH; n++;
			end
			if (fc + 1 < w && mdl_marks[seed_at + 1] == 0) begin
				open_dirs[n] = gtmc_pkg::DIR_EAST; n++;
			end
			if (n == 0) begin
				mdl_seeds[idx] = mdl_seeds[mdl_seed_cnt - 1];
				mdl_seed_cnt--;
				r.seed_removed = 1'b1;
			end else begin
				dir = open_dirs[int'(it.rd) % n];
				if (dir == gtmc_pkg::DIR_NORTH) nxt = seed_at - MAX_SIDE;
				else if (dir == gtmc_pkg::DIR_WEST) nxt = seed_at - 1;
				else if (dir == gtmc_pkg::DIR_SOUTH) nxt = seed_at + MAX_SIDE;
				else nxt = seed_at + 1;
				mdl_marks[seed_at][dir] = 1'b1;
				mdl_marks[nxt][dir ^ 2] = 1'b1;
				if (mdl_seed_cnt < CELLS) begin
					mdl_seeds[mdl_seed_cnt] = gtmc_pkg::CELL_W'(nxt);
					mdl_seed_cnt++;
				end
				r.carve_dir = 2'(dir);
				r.carved = 1'b1;
			end
		end
		r.finished = (mdl_seed_cnt == 0);
		r.seeds_left = gtmc_pkg::CNT_W'(mdl_seed_cnt);
		return r;
	endfunction

	// command driver: holds an item until taken, idles at random between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				taken_item = pending_items.pop_front();
				expected_results.push_back(carve_predict(taken_item));
			end
			if (in_ch.valid && !in_ch.ready) begin
				// item still on offer, keep it
			end else if (pending_items.size() > 0 &&
					$urandom_range(0, 99) >= src_idle_pct) begin
				in_ch.valid       <= 1'b1;
				in_ch.command     <= pending_items[0].command;
				in_ch.cell_row    <= pending_items[0].row;
				in_ch.cell_col    <= pending_items[0].col;
				in_ch.cell_weight <= pending_items[0].weight;
				in_ch.rand_jump   <= pending_items[0].rj;
				in_ch.rand_index  <= pending_items[0].ri;
				in_ch.rand_dir    <= pending_items[0].rd;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor: random back-pressure, field-by-field compare with the oldest
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				seen_result.from_row     = out_ch.from_row;
				seen_result.from_col     = out_ch.from_col;
				seen_result.carve_dir    = out_ch.carve_dir;
				seen_result.carved       = out_ch.carved;
				seen_result.seed_removed = out_ch.seed_removed;
				seen_result.finished     = out_ch.finished;
				seen_result.seeds_left   = out_ch.seeds_left;
				if (expected_results.size() == 0) begin
					$error("result item with no item outstanding");
					fail_count++;
				end else begin
					want_result = expected_results.pop_front();
					if (seen_result.from_row !== want_result.from_row) begin
						$error("from_row: expected %0d, actual %0d",
							want_result.from_row, seen_result.from_row);
						fail_count++;
					end
					if (seen_result.from_col !== want_result.from_col) begin
						$error("from_col: expected %0d, actual %0d",
							want_result.from_col, seen_result.from_col);
						fail_count++;
					end
					if (seen_result.carve_dir !== want_result.carve_dir) begin
						$error("carve_dir: expected %0d, actual %0d",
							want_result.carve_dir, seen_result.carve_dir);
						fail_count++;
					end
					if (seen_result.carved !== want_result.carved) begin
						$error("carved: expected %0d, actual %0d",
							want_result.carved, seen_result.carved);
						fail_count++;
					end
					if (seen_result.seed_removed !== want_result.seed_removed) begin
						$error("seed_removed: expected %0d, actual %0d",
							want_result.seed_removed, seen_result.seed_removed);
						fail_count++;
					end
					if (seen_result.finished !== want_result.finished) begin
						$error("finished: expected %0d, actual %0d",
							want_result.finished, seen_result.finished);
						fail_count++;
					end
					if (seen_result.seeds_left !== want_result.seeds_left) begin
						$error("seeds_left: expected %0d, actual %0d",
							want_result.seeds_left, seen_result.seeds_left);
						fail_count++;
					end
				end
			end
			out_ch.ready <= $urandom_range(0, 99) >= snk_stall_pct;
		end
	end

	function automatic carve_item_t make_item(logic [1:0] cmd, int row, int col, int wgt,
			int rj, int ri, int rd);
		carve_item_t it;
		it.command = cmd;
		it.row = gtmc_pkg::SIDE_W'(row);
		it.col = gtmc_pkg::SIDE_W'(col);
		it.weight = gtmc_pkg::WGT_W'(wgt);
		it.rj = gtmc_pkg::RAND_W'(rj);
		it.ri = gtmc_pkg::RAND_W'(ri);
		it.rd = gtmc_pkg::RAND_W'(rd);
		return it;
	endfunction

	task automatic queue_item(carve_item_t it);
		pending_items.push_back(it);
	endtask

	// random item with mostly growth steps, some loads, restarts and dead codes
	task automatic queue_random_item();
		int pick;
		carve_item_t it;
		pick = $urandom_range(0, 99);
		it = make_item(gtmc_pkg::CMD_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
			$urandom_range(0, 127), $urandom_range(0, 32767), $urandom_range(0, 32767),
			$urandom_range(0, 32767));
		if (pick < 3) it.command = gtmc_pkg::CMD_START;
		else if (pick < 11) it.command = gtmc_pkg::CMD_LOAD;
		else if (pick < 14) it.command = CMD_NONE;
		queue_item(it);
	endtask

	// let everything outstanding drain, then let the sequencer settle
	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_results.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(logic [gtmc_pkg::CFG_IDX_W-1:0] idx,
			logic [gtmc_pkg::CFG_DAT_W-1:0] dat);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= dat;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == gtmc_pkg::REG_WIDTH) mdl_width = int'(dat[gtmc_pkg::DIM_W-1:0]);
		else if (idx == gtmc_pkg::REG_HEIGHT) mdl_height = int'(dat[gtmc_pkg::DIM_W-1:0]);
		else if (idx == gtmc_pkg::REG_MODE) mdl_mode = int'(dat[0]);
		else mdl_jump = int'(dat);
		@(posedge clk);
	endtask

	// one phase: new setting, full weights for weighted choice, fresh maze, random items
	task automatic run_phase(int ph, int w, int h, int mode, int jf, int count, bit flat);
		int r, c, k, wgt;
		wait_drained();
		cfg_write(gtmc_pkg::REG_WIDTH, gtmc_pkg::CFG_DAT_W'(w));
		cfg_write(gtmc_pkg::REG_HEIGHT, gtmc_pkg::CFG_DAT_W'(h));
		cfg_write(gtmc_pkg::REG_MODE, gtmc_pkg::CFG_DAT_W'(mode));
		cfg_write(gtmc_pkg::REG_JUMP, gtmc_pkg::CFG_DAT_W'(jf));
		case (ph % 4)
			0: begin src_idle_pct = 0; snk_stall_pct = 0; end
			1: begin src_idle_pct = 53; snk_stall_pct = 0; end
			2: begin src_idle_pct = 0; snk_stall_pct = 53; end
			default: begin src_idle_pct = 10; snk_stall_pct = 10; end
		endcase
		@(negedge clk);
		if (mode != 0) begin
			for (r = 0; r < eff_side(h); r++) begin
				for (c = 0; c < eff_side(w); c++) begin
					k = $urandom_range(0, 7);
					if (flat || k < 2) wgt = 0;
					else if (k == 2) wgt = HEAVIEST;
					else wgt = $urandom_range(1, 127);
					queue_item(make_item(gtmc_pkg::CMD_LOAD, r, c, wgt, 0, 0, 0));
				end
			end
		end
		queue_item(make_item(gtmc_pkg::CMD_START, $urandom_range(0, 63),
			$urandom_range(0, 63), 0, 0, 0, 0));
		for (k = 0; k < count; k++) queue_random_item();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		fail_count = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_NONE;
		in_ch.cell_row = '0;
		in_ch.cell_col = '0;
		in_ch.cell_weight = '0;
		in_ch.rand_jump = '0;
		in_ch.rand_index = '0;
		in_ch.rand_dir = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = gtmc_pkg::REG_WIDTH;
		cfg_ch.data = '0;
		mdl_seed_cnt = 0;
		mdl_width = 64;
		mdl_height = 64;
		mdl_mode = 0;
		mdl_jump = 8;
		for (int k = 0; k < CELLS; k++) begin
			mdl_marks[k] = 4'd0;
			mdl_seeds[k] = '0;
			mdl_weights[k] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part at reset settings
		queue_item(make_item(gtmc_pkg::CMD_STEP, 5, 5, 0, 0, 0, 0));   // step with no seeds
		queue_item(make_item(CMD_NONE, 63, 63, 127, 32767, 32767, 32767));
		queue_item(make_item(gtmc_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0));
		queue_item(make_item(gtmc_pkg::CMD_LOAD, 63, 63, 127, 0, 0, 0)); // above top weight
		queue_item(make_item(gtmc_pkg::CMD_LOAD, 63, 0, HEAVIEST, 0, 0, 0));
		queue_item(make_item(gtmc_pkg::CMD_START, 63, 63, 0, 0, 0, 0)); // far corner
		queue_item(make_item(gtmc_pkg::CMD_STEP, 0, 0, 0, 32767, 32767, 32767));
		queue_item(make_item(gtmc_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0));    // forced jump
		queue_item(make_item(gtmc_pkg::CMD_STEP, 0, 0, 0, 1, 32767, 1));
		queue_item(make_item(gtmc_pkg::CMD_STEP, 0, 0, 0, 8, 3, 2));
		queue_item(make_item(gtmc_pkg::CMD_START, 0, 0, 0, 0, 0, 0));   // near corner
		queue_item(make_item(gtmc_pkg::CMD_STEP, 0, 0, 0, 1, 0, 0));
		queue_item(make_item(gtmc_pkg::CMD_STEP, 0, 0, 0, 1, 0, 1));
		queue_item(make_item(gtmc_pkg::CMD_STEP, 0, 0, 0, 7, 0, 32767));
		queue_item(make_item(gtmc_pkg::CMD_STEP, 0, 0, 0, 0, 32767, 0));
		queue_item(make_item(CMD_NONE, 0, 0, 0, 0, 0, 0));
		queue_item(make_item(gtmc_pkg::CMD_START, 31, 32, 0, 0, 0, 0));
		queue_item(make_item(gtmc_pkg::CMD_STEP, 0, 0, 0, 5, 5, 5));

		// small grids finish, odd sizes wrap and clamp, both choice modes
		run_phase(1, 2, 2, 0, 1, 30, 1'b0);
		run_phase(2, 0, 0, 0, 0, 20, 1'b0);      // zero sizes and zero jump factor
		run_phase(3, 5, 3, 1, 8, 30, 1'b1);      // weighted, no weight above zero
		run_phase(4, 127, 127, 0, 255, 30, 1'b0); // oversize grid clamps
		run_phase(5, 8, 8, 1, 5, 30, 1'b0);
		run_phase(6, 3, 7, 0, 3, 30, 1'b0);
		run_phase(7, 64, 2, 1, 1, 30, 1'b0);
		run_phase(8, 4, 4, 0, 2, 30, 1'b0);
		run_phase(9, 2, 64, 1, 200, 30, 1'b0);
		run_phase(10, 6, 5, 0, 128, 30, 1'b0);

		wait_drained();
		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("** growing_tree_maze_carver_unit: PASSED **");
		end else begin
			$display("** growing_tree_maze_carver_unit: FAILED **");
		end
		$finish;
	end

	// watchdog
	initial begin
		#40_000_000;
		$display("** growing_tree_maze_carver_unit: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/gtmc_pkg.sv
hw/rtl/gtmc_if.sv
hw/rtl/gtmc_divider.sv
hw/rtl/growing_tree_maze_carver_unit.sv
test/testbench.sv
